### rtl/alr_pkg.sv
// ----------------------------------------------------------------------------
// alr_pkg
// Shared constants and types of the anti-aliased line rasterizer.
// ----------------------------------------------------------------------------
package alr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ALPHA_W        = 8;

    localparam logic [ALPHA_W-1:0] ALPHA_HALF = 8'd127;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'd255;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic div_step;
        logic finish;
        logic emit_first;
        logic emit_body;
        logic emit_final;
    } alr_cmd_t;

    typedef struct packed {
        logic room;
        logic col_more;
    } alr_stat_t;

endpackage

### rtl/alr_dp.sv
// ----------------------------------------------------------------------------
// alr_dp
// Datapath: endpoint setup, serial gradient divider, row accumulator,
// coverage computation and a two-entry result queue.
// ----------------------------------------------------------------------------
module alr_dp import alr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int PIX_W     = 2 * (COORD_BITS + 1) + ALPHA_W,
    localparam int TDATA_W   = ((PIX_W + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  alr_cmd_t                cmd,
    output alr_stat_t               stat,
    input  logic [4*COORD_BITS-1:0] ends,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDATA_W-1:0]      m_tdata,
    output logic                    m_tlast
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int A     = C + F + 1;
    localparam int ENT_W = PIX_W + 1;

    logic signed [C-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic                steep_reg;
    logic signed [C-1:0] column_reg, last_column_reg, first_row_reg, last_row_reg;
    logic [C-1:0]        divisor_reg;
    logic [C:0]          rem_reg;
    logic [F:0]          quo_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic signed [F+1:0] slope_reg;
    logic signed [A-1:0] acc_reg;
    logic [ENT_W-1:0]    q0_reg, q1_reg;
    logic [1:0]          cnt_reg;

    logic signed [C:0]   dxs, dys, maj_d, min_d, dy_ord, dx_w, dy_mag, adx_w, ady_w;
    logic                steep_w, swap_w;
    logic signed [C-1:0] pa_maj, pa_min, pb_maj, pb_min;
    logic [C:0]          rem_sub, rem_sel;
    logic                ge;
    logic signed [F+1:0] q_ext, slope_w;
    logic signed [A-1:0] acc_init;
    logic signed [C:0]   col_ext, col_inc, row, row1;
    logic [F-1:0]        frac;
    logic [F+7:0]        prod, full;
    logic [ALPHA_W-1:0]  a0, a1;
    logic [ENT_W-1:0]    p0, p1, r0, r1;
    logic [1:0]          new_n;
    logic                pop;

    function automatic logic [ENT_W-1:0] pixel(input logic steep,
                                               input logic signed [C:0] maj,
                                               input logic signed [C:0] mnr,
                                               input logic [ALPHA_W-1:0] alpha,
                                               input logic last);
        logic [ENT_W-1:0] r;
        if (steep) begin
            r = {last, alpha, maj, mnr};
        end else begin
            r = {last, alpha, mnr, maj};
        end
        return r;
    endfunction

    // Endpoint setup: axis swap for steep lines, ordering by major coordinate.
    always_comb begin
        dxs     = {x1_reg[C-1], x1_reg} - {x0_reg[C-1], x0_reg};
        dys     = {y1_reg[C-1], y1_reg} - {y0_reg[C-1], y0_reg};
        adx_w   = dxs[C] ? -dxs : dxs;
        ady_w   = dys[C] ? -dys : dys;
        steep_w = $unsigned(ady_w) > $unsigned(adx_w);
        maj_d   = steep_w ? dys : dxs;
        min_d   = steep_w ? dxs : dys;
        swap_w  = maj_d[C];
        dx_w    = swap_w ? -maj_d : maj_d;
        dy_ord  = swap_w ? -min_d : min_d;
        dy_mag  = dy_ord[C] ? -dy_ord : dy_ord;
        pa_maj  = steep_w ? y0_reg : x0_reg;
        pa_min  = steep_w ? x0_reg : y0_reg;
        pb_maj  = steep_w ? y1_reg : x1_reg;
        pb_min  = steep_w ? x1_reg : y1_reg;
    end

    // One restoring division step per cycle.
    always_comb begin
        ge      = rem_reg >= {1'b0, divisor_reg};
        rem_sub = rem_reg - {1'b0, divisor_reg};
        rem_sel = ge ? rem_sub : rem_reg;
    end

    always_comb begin
        q_ext    = {1'b0, quo_reg};
        if (zero_reg) begin
            slope_w = {2'b01, {F{1'b0}}};
        end else begin
            slope_w = neg_reg ? -q_ext : q_ext;
        end
        acc_init = {first_row_reg[C-1], first_row_reg, {F{1'b0}}}
                 + {{(A-F-2){slope_w[F+1]}}, slope_w};
    end

    always_comb begin
        col_ext = {column_reg[C-1], column_reg};
        col_inc = col_ext + {{C{1'b0}}, 1'b1};
        frac    = acc_reg[F-1:0];
        row     = acc_reg[A-1:F];
        row1    = row + {{C{1'b0}}, 1'b1};
        prod    = {frac, 8'b0} - {8'b0, frac};
        full    = {ALPHA_FULL, {F{1'b0}}} - prod;
        a1      = prod[F+7:F];
        a0      = full[F+7:F];
    end

    assign stat.col_more = col_inc < $signed({last_column_reg[C-1], last_column_reg});
    assign stat.room     = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    always_comb begin
        p0    = '0;
        p1    = '0;
        new_n = 2'd0;
        priority if (cmd.emit_first) begin
            p0    = pixel(steep_reg, col_ext, {first_row_reg[C-1], first_row_reg},
                          ALPHA_HALF, 1'b0);
            new_n = 2'd1;
        end else if (cmd.emit_final) begin
            p0    = pixel(steep_reg, {last_column_reg[C-1], last_column_reg},
                          {last_row_reg[C-1], last_row_reg}, ALPHA_HALF, 1'b1);
            new_n = 2'd1;
        end else if (cmd.emit_body) begin
            p0    = pixel(steep_reg, col_ext, row, a0, 1'b0);
            p1    = pixel(steep_reg, col_ext, row1, a1, 1'b0);
            new_n = {1'b0, a0 != '0} + {1'b0, a1 != '0};
        end else begin
            new_n = 2'd0;
        end
        if (cmd.emit_body && (a0 == '0)) begin
            r0 = p1;
        end else begin
            r0 = p0;
        end
        r1 = p1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x0_reg <= ends[C-1:0];
            y0_reg <= ends[2*C-1:C];
            x1_reg <= ends[3*C-1:2*C];
            y1_reg <= ends[4*C-1:3*C];
        end
        if (cmd.setup) begin
            steep_reg       <= steep_w;
            column_reg      <= swap_w ? pb_maj : pa_maj;
            first_row_reg   <= swap_w ? pb_min : pa_min;
            last_column_reg <= swap_w ? pa_maj : pb_maj;
            last_row_reg    <= swap_w ? pa_min : pb_min;
            divisor_reg     <= dx_w[C-1:0];
            rem_reg         <= {1'b0, dy_mag[C-1:0]};
            quo_reg         <= '0;
            neg_reg         <= dy_ord[C];
            zero_reg        <= dx_w == '0;
        end
        if (cmd.div_step) begin
            rem_reg <= {rem_sel[C-1:0], 1'b0};
            quo_reg <= {quo_reg[F-1:0], ge};
        end
        if (cmd.finish) begin
            slope_reg <= slope_w;
            acc_reg   <= acc_init;
        end
        if (cmd.emit_first || cmd.emit_body) begin
            column_reg <= col_inc[C-1:0];
        end
        if (cmd.emit_body) begin
            acc_reg <= acc_reg + {{(A-F-2){slope_reg[F+1]}}, slope_reg};
        end
    end

    assign pop = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (cmd.emit_first || cmd.emit_body || cmd.emit_final) begin
            cnt_reg <= new_n;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_first || cmd.emit_body || cmd.emit_final) begin
            q0_reg <= r0;
            q1_reg <= r1;
        end else if (pop) begin
            q0_reg <= q1_reg;
        end
    end

    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = TDATA_W'(q0_reg[PIX_W-1:0]);
    assign m_tlast  = q0_reg[PIX_W];

endmodule

### rtl/alr_ctrl.sv
// ----------------------------------------------------------------------------
// alr_ctrl
// Controller: line phases, divider sequencing and input handshake.
// ----------------------------------------------------------------------------
module alr_ctrl import alr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      s_tuser,
    input  alr_stat_t stat,
    output alr_cmd_t  cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_FINISH,
        ST_FIRST,
        ST_BODY,
        ST_FINAL
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             open_w, accept, is_start;

    assign open_w   = (state_reg == ST_IDLE) || (state_reg == ST_FIRST)
                   || (state_reg == ST_BODY) || (state_reg == ST_FINAL);
    assign s_tready = open_w && stat.room;
    assign accept   = s_tvalid && s_tready;
    assign is_start = s_tuser == CMD_START;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.load       = accept && is_start;
        cmd.emit_first = accept && !is_start && (state_reg == ST_FIRST);
        cmd.emit_body  = accept && !is_start && (state_reg == ST_BODY);
        cmd.emit_final = accept && !is_start && (state_reg == ST_FINAL);
        unique case (state_reg)
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRAC_BITS)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_FIRST;
            end
            ST_IDLE, ST_FIRST, ST_BODY, ST_FINAL: begin
                if (accept && is_start) begin
                    state_next = ST_SETUP;
                end else if (accept) begin
                    priority case (state_reg)
                        ST_FIRST, ST_BODY: begin
                            state_next = stat.col_more ? ST_BODY : ST_FINAL;
                        end
                        ST_FINAL: begin
                            state_next = ST_IDLE;
                        end
                        default: begin
                            state_next = state_reg;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/antialiased_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_unit
// Anti-aliased line rasterizer with fixed-point gradient and alpha coverage.
//
//   Channel  Dir  Contents
//   s_       in   tuser: command; tdata: start_x, start_y, end_x, end_y
//   m_       out  tdata: pixel_x, pixel_y, alpha; tlast: last_pixel
//
// After a start request is taken, input ready stays low through the setup,
// restoring division and finish states that form the gradient.
// A step request that yields two pixels holds off the next request until
// the two-entry result queue is down to one entry that is being taken.
// Reset is synchronous and returns the unit to idle with an empty queue.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_unit import alr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_W      = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int PIX_W     = 2 * (COORD_BITS + 1) + ALPHA_W,
    localparam int OUT_W     = ((PIX_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y
    input  logic             s_tuser,   // command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // pixel_x, pixel_y, alpha
    output logic             m_tlast
);

    alr_cmd_t  cmd;
    alr_stat_t stat;

    alr_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .stat    (stat),
        .cmd     (cmd)
    );

    alr_dp #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .ends    (s_tdata[4*COORD_BITS-1:0]),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    localparam int ALPHA_LSB = 2 * (COORD_BITS + 1);

    a_start_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_START)) |=> !s_tready)
        else $error("input ready while gradient is being formed");

    a_alpha_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[ALPHA_LSB +: ALPHA_W] != '0))
        else $error("zero-coverage pixel presented");

    a_last_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[ALPHA_LSB +: ALPHA_W] == ALPHA_HALF))
        else $error("endpoint pixel with wrong coverage");

endmodule

### bench/line_pixel_checker.sv
// ----------------------------------------------------------------------------
// line_pixel_checker
// Watches both stream channels of the line rasterizer, predicts the pixels
// of every accepted request and compares each delivered pixel in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pixel_checker import alr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int IN_W       = 48,
    parameter int OUT_W      = 40
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             m_tlast,
    output int               failures,
    output int               outstanding
);

    localparam int     PW  = COORD_BITS + 1;
    localparam longint ONE = longint'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        SEG_IDLE,
        SEG_FIRST,
        SEG_BODY,
        SEG_FINAL
    } seg_phase_t;

    typedef struct packed {
        logic [PW-1:0]      px;
        logic [PW-1:0]      py;
        logic [ALPHA_W-1:0] alpha;
        logic               is_last;
    } pixel_t;

    pixel_t     pixel_queue[$];
    seg_phase_t seg_phase;
    bit         steep;
    longint     col;
    longint     col_end;
    longint     row_first;
    longint     row_end;
    longint     row_acc;
    longint     gradient;
    int         printed;

    initial begin
        failures    = 0;
        outstanding = 0;
        printed     = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        failures++;
        if (printed < 100) begin
            printed++;
            $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    task automatic queue_pixel(input longint major, input longint minor, input longint a,
                               input bit is_last);
        pixel_t p;
        if (a == 0) begin
            return;
        end
        p.px      = steep ? minor[PW-1:0] : major[PW-1:0];
        p.py      = steep ? major[PW-1:0] : minor[PW-1:0];
        p.alpha   = a[ALPHA_W-1:0];
        p.is_last = is_last;
        pixel_queue.push_back(p);
    endtask

    task automatic next_column();
        col++;
        seg_phase = (col < col_end) ? SEG_BODY : SEG_FINAL;
    endtask

    task automatic predict_request(input logic cmd, input logic [IN_W-1:0] data);
        longint x0, y0, x1, y1, adx, ady, dx, dy, mag, f, row;
        if (cmd == CMD_START) begin
            x0 = $signed(data[COORD_BITS-1:0]);
            y0 = $signed(data[2*COORD_BITS-1:COORD_BITS]);
            x1 = $signed(data[3*COORD_BITS-1:2*COORD_BITS]);
            y1 = $signed(data[4*COORD_BITS-1:3*COORD_BITS]);
            adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
            ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
            steep = ady > adx;
            if (steep) begin
                {x0, y0} = {y0, x0};
                {x1, y1} = {y1, x1};
            end
            if (x0 > x1) begin
                {x0, x1} = {x1, x0};
                {y0, y1} = {y1, y0};
            end
            dx = x1 - x0;
            dy = y1 - y0;
            if (dx == 0) begin
                gradient = ONE;
            end else begin
                mag      = (dy < 0) ? -dy : dy;
                gradient = (mag << FRAC_BITS) / dx;
                if (dy < 0) begin
                    gradient = -gradient;
                end
            end
            col       = x0;
            col_end   = x1;
            row_first = y0;
            row_end   = y1;
            row_acc   = y0 * ONE + gradient;
            seg_phase = SEG_FIRST;
        end else begin
            case (seg_phase)
                SEG_FIRST: begin
                    queue_pixel(col, row_first, ALPHA_HALF, 1'b0);
                    next_column();
                end
                SEG_BODY: begin
                    f   = row_acc & (ONE - 1);
                    row = row_acc >>> FRAC_BITS;
                    queue_pixel(col, row, ((ONE - f) * ALPHA_FULL) >> FRAC_BITS, 1'b0);
                    queue_pixel(col, row + 1, (f * ALPHA_FULL) >> FRAC_BITS, 1'b0);
                    row_acc += gradient;
                    next_column();
                end
                SEG_FINAL: begin
                    queue_pixel(col_end, row_end, ALPHA_HALF, 1'b1);
                    seg_phase = SEG_IDLE;
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (pixel_queue.size() == 0) begin
            report_mismatch("pixel with no request pending", m_tdata[PW-1:0], 0);
            return;
        end
        want = pixel_queue.pop_front();
        if (m_tdata[PW-1:0] !== want.px) begin
            report_mismatch("pixel_x", m_tdata[PW-1:0], want.px);
        end
        if (m_tdata[2*PW-1:PW] !== want.py) begin
            report_mismatch("pixel_y", m_tdata[2*PW-1:PW], want.py);
        end
        if (m_tdata[2*PW+ALPHA_W-1:2*PW] !== want.alpha) begin
            report_mismatch("alpha", m_tdata[2*PW+ALPHA_W-1:2*PW], want.alpha);
        end
        if (m_tlast !== want.is_last) begin
            report_mismatch("last_pixel", m_tlast, want.is_last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pixel_queue.delete();
            seg_phase   = SEG_IDLE;
            steep       = 1'b0;
            col         = 0;
            col_end     = 0;
            row_first   = 0;
            row_end     = 0;
            row_acc     = 0;
            gradient    = 0;
            outstanding <= 0;
        end else begin
            // Outputs of a request can only appear after the request is taken,
            // so predicting first keeps the queue in delivery order.
            if (s_tvalid && s_tready) begin
                predict_request(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_pixel();
            end
            outstanding <= pixel_queue.size();
        end
    end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives start and step requests into the anti-aliased line rasterizer with
// random gaps on both channels: directed lines first, then random short
// lines, abandoned lines and stray requests. The checker grades the pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import alr_pkg::*;

    localparam int COORD_BITS = COORD_BITS_DEF;
    localparam int FRAC_BITS  = FRAC_BITS_DEF;
    localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W      = ((2 * (COORD_BITS + 1) + ALPHA_W + 7) / 8) * 8;
    localparam int CMIN       = -(1 << (COORD_BITS - 1));
    localparam int CMAX       = (1 << (COORD_BITS - 1)) - 1;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             s_tuser  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    int failures;
    int outstanding;
    int sent;
    int tx_calm;
    int rx_calm;
    bit drained_mid;

    always #5 aclk = ~aclk;

    antialiased_line_rasterizer_unit #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    line_pixel_checker #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (IN_W),
        .OUT_W     (OUT_W)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .failures   (failures),
        .outstanding(outstanding)
    );

    // Mostly random waits, with occasional runs of back-to-back transfers.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < CMIN) ? CMIN : (v > CMAX) ? CMAX : v;
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(0, 4) == 0) begin
            return $urandom_range(0, 1) ? CMAX - int'($urandom_range(0, 3))
                                        : CMIN + int'($urandom_range(0, 3));
        end
        return int'($urandom_range(0, CMAX - CMIN)) + CMIN;
    endfunction

    function automatic logic [IN_W-1:0] random_bits();
        return IN_W'({$urandom, $urandom});
    endfunction

    function automatic logic [IN_W-1:0] pack_line(input int x0, input int y0,
                                                   input int x1, input int y1);
        logic [IN_W-1:0] d;
        d = '0;
        d[4*COORD_BITS-1:0] = {y1[COORD_BITS-1:0], x1[COORD_BITS-1:0],
                               y0[COORD_BITS-1:0], x0[COORD_BITS-1:0]};
        return d;
    endfunction

    task automatic send_request(input logic cmd, input logic [IN_W-1:0] data);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                             input int steps);
        send_request(CMD_START, pack_line(x0, y0, x1, y1));
        repeat (steps) send_request(CMD_STEP, random_bits());
    endtask

    task automatic wait_all_delivered();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Short lines run to completion or are cut off; a few have random endpoints
    // and at most five steps, so are mostly abandoned by the next start request.
    task automatic random_line();
        int x0, y0, x1, y1, span, len, steps, pick;
        pick = $urandom_range(0, 9);
        x0 = rand_coord();
        y0 = rand_coord();
        if (pick == 0) begin
            x1    = rand_coord();
            y1    = rand_coord();
            steps = $urandom_range(0, 5);
        end else begin
            span = (pick == 1) ? 1 : $urandom_range(2, 12);
            x1   = clamp_coord(x0 + int'($urandom_range(0, 2 * span)) - span);
            y1   = clamp_coord(y0 + int'($urandom_range(0, 2 * span)) - span);
            len  = (x1 > x0) ? x1 - x0 : x0 - x1;
            if (((y1 > y0) ? y1 - y0 : y0 - y1) > len) begin
                len = (y1 > y0) ? y1 - y0 : y0 - y1;
            end
            len   = (len == 0) ? 2 : len + 1;
            steps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1)
                                                : len + $urandom_range(0, 2);
        end
        draw_line(x0, y0, x1, y1, steps);
    endtask

    initial begin
        @(posedge aclk);
        forever begin
            int gap;
            gap = draw_gap(rx_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        sent        = 0;
        tx_calm     = 0;
        rx_calm     = 0;
        drained_mid = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // A step request with no line loaded yields nothing.
        send_request(CMD_STEP, random_bits());
        draw_line(CMIN, CMIN, CMAX, CMAX, 3);
        draw_line(CMAX, CMIN, CMIN, CMAX, 2);
        draw_line(3, 3, 3, 3, 3);
        draw_line(10, 5, 11, 7, 3);
        draw_line(0, 0, 1, 0, 2);
        draw_line(1, -1, -1, 2, 4);
        draw_line(-5, CMAX, -2, CMAX, 5);
        wait_all_delivered();

        while (sent < 540) begin
            if (!drained_mid && sent >= 320) begin
                wait_all_delivered();
                drained_mid = 1'b1;
            end
            if ($urandom_range(0, 99) < 15) begin
                send_request($urandom_range(0, 1) ? CMD_STEP : CMD_START, random_bits());
            end else begin
                random_line();
            end
        end

        wait_all_delivered();
        repeat (FRAC_BITS + 10) @(posedge aclk);
        if (failures == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
